FILE: hdl/fmdu_pkg.sv
// ---------------------------------------------------------------------------
// fmdu_pkg
// shared types and constants of the fixed-point multiply / divide unit
// ---------------------------------------------------------------------------
package fmdu_pkg;

    localparam int FIELD_WIDTH  = 32;
    localparam int RESULT_WIDTH = 64;

    localparam logic [RESULT_WIDTH-1:0] ZERO_DIV_VALUE = 64'h0000_0000_7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_MUL    = 2'd0,
        CMD_DIV    = 2'd1,
        CMD_MULDIV = 2'd2
    } t_cmd;

    // control that rides along with the data through the divider chain
    typedef struct packed {
        logic [1:0] cmd;
        logic       neg;
        logic       dz;
    } t_side;

endpackage

FILE: hdl/fmdu_if.sv
// ---------------------------------------------------------------------------
// fmdu_in_if / fmdu_out_if
// valid / ready channels of the fixed-point multiply / divide unit
// ---------------------------------------------------------------------------
interface fmdu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;

    modport source (output valid, command, operand_a, operand_b, operand_c, input ready);
    modport sink   (input valid, command, operand_a, operand_b, operand_c, output ready);
endinterface

interface fmdu_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result;
    logic               divide_by_zero;

    modport source (output valid, result, divide_by_zero, input ready);
    modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

FILE: hdl/fmdu_div_cell.sv
// ---------------------------------------------------------------------------
// fmdu_div_cell
// one restoring-division cell: resolves one quotient bit per pass
// ---------------------------------------------------------------------------
module fmdu_div_cell
    import fmdu_pkg::*;
#(
    parameter int NW = 63,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [NW-1:0] i_nq,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    output logic          o_valid,
    output t_side         o_side,
    output logic [NW-1:0] o_nq,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_div
);
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic          r_valid;
    t_side         r_side;
    logic [NW-1:0] r_nq;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    // bring down the next numerator bit, try to subtract
    assign w_trial = {i_rem, i_nq[NW-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = (w_trial >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_div  <= i_div;
            r_nq   <= {i_nq[NW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
endmodule

FILE: hdl/fixed_point_mul_div_unit_core.sv
// ---------------------------------------------------------------------------
// fixed_point_mul_div_unit_core
// signed fixed-point multiply, divide and multiply-then-divide, pipelined
// ---------------------------------------------------------------------------
// channel | dir | payload                                        | transfer
// i_in    | in  | command, operand_a, operand_b, operand_c       | valid & ready
// o_out   | out | result, divide_by_zero                         | valid & ready
//
// one transfer per cycle in and out while the output is not stalled
// pipeline: magnitude stage, product stage, 2*OPERAND_WIDTH-1 divider cells, output reg
// the chain of divider cells sets the latency, one quotient bit per cell
// synchronous active-low reset clears the valid bits only
// a stalled output freezes the whole pipe; i_in.ready follows that freeze
// ---------------------------------------------------------------------------
module fixed_point_mul_div_unit_core
    import fmdu_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmdu_in_if.sink     i_in,
    fmdu_out_if.source  o_out
);
    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;       // full product
    localparam int NW = 2 * OW - 1;   // numerator / quotient width

    // whole pipe moves unless the output register holds an untaken result
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // -------- stage 1: magnitudes, signs, zero divisor --------
    logic [OW-1:0] w_va, w_vb, w_vc;
    logic [OW-1:0] w_ma, w_mb, w_mc;
    logic          w_na, w_nb, w_nc;
    t_side         w_side1;

    assign w_va = i_in.operand_a[OW-1:0];
    assign w_vb = i_in.operand_b[OW-1:0];
    assign w_vc = i_in.operand_c[OW-1:0];
    assign w_na = w_va[OW-1];
    assign w_nb = w_vb[OW-1];
    assign w_nc = w_vc[OW-1];
    // most negative value maps onto 2^(OW-1) as an unsigned magnitude
    assign w_ma = w_na ? (~w_va + 1'b1) : w_va;
    assign w_mb = w_nb ? (~w_vb + 1'b1) : w_vb;
    assign w_mc = w_nc ? (~w_vc + 1'b1) : w_vc;

    always_comb begin
        w_side1.cmd = i_in.command;
        w_side1.neg = 1'b0;
        w_side1.dz  = 1'b0;
        unique case (t_cmd'(i_in.command))
            CMD_MUL: begin
                w_side1.neg = w_na ^ w_nb;
            end
            CMD_DIV: begin
                w_side1.neg = w_na ^ w_nb;
                w_side1.dz  = (w_mb == '0);
            end
            CMD_MULDIV: begin
                w_side1.neg = w_na ^ w_nb ^ w_nc;
                w_side1.dz  = (w_mc == '0);
            end
            default: begin
                w_side1.neg = 1'b0;
            end
        endcase
    end

    logic          r_s1_valid;
    t_side         r_s1_side;
    logic [OW-1:0] r_s1_ma, r_s1_mb, r_s1_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in.valid;
        end
        if (w_en) begin
            r_s1_side <= w_side1;
            r_s1_ma   <= w_ma;
            r_s1_mb   <= w_mb;
            r_s1_mc   <= w_mc;
        end
    end

    // -------- stage 2: magnitude product --------
    logic          r_s2_valid;
    t_side         r_s2_side;
    logic [PW-1:0] r_s2_prod;
    logic [OW-1:0] r_s2_ma, r_s2_mb, r_s2_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_en) begin
            r_s2_side <= r_s1_side;
            r_s2_prod <= PW'(r_s1_ma) * PW'(r_s1_mb);
            r_s2_ma   <= r_s1_ma;
            r_s2_mb   <= r_s1_mb;
            r_s2_mc   <= r_s1_mc;
        end
    end

    // -------- numerator and divisor into the cell chain --------
    // multiply runs through the chain with a divisor of one
    logic [NW-1:0] w_num;
    logic [OW-1:0] w_dvs;
    logic [PW-1:0] w_mul_round;

    // zero divisor is replaced by one; the flag overrides the quotient later
    function automatic logic [OW-1:0] r_s2_dz_guard(input logic [OW-1:0] d);
        return (d == '0) ? OW'(1) : d;
    endfunction

    assign w_mul_round = r_s2_prod + (PW'(1) << (FRACTION_BITS - 1));

    always_comb begin
        w_num = '0;
        w_dvs = OW'(1);
        case (r_s2_side.cmd)
            CMD_MUL: begin
                w_num = NW'(w_mul_round >> FRACTION_BITS);
            end
            CMD_DIV: begin
                w_num = (NW'(r_s2_ma) << FRACTION_BITS) + NW'(r_s2_mb >> 1);
                w_dvs = r_s2_dz_guard(r_s2_mb);
            end
            CMD_MULDIV: begin
                w_num = NW'(r_s2_prod + PW'(r_s2_mc >> 1));
                w_dvs = r_s2_dz_guard(r_s2_mc);
            end
            default: begin
                w_num = '0;
            end
        endcase
    end

    // -------- divider cell chain --------
    logic          c_valid [NW+1];
    t_side         c_side  [NW+1];
    logic [NW-1:0] c_nq    [NW+1];
    logic [OW-1:0] c_rem   [NW+1];
    logic [OW-1:0] c_div   [NW+1];

    assign c_valid[0] = r_s2_valid;
    assign c_side[0]  = r_s2_side;
    assign c_nq[0]    = w_num;
    assign c_rem[0]   = '0;
    assign c_div[0]   = w_dvs;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        fmdu_div_cell #(
            .NW (NW),
            .DW (OW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_valid[g]),
            .i_side  (c_side[g]),
            .i_nq    (c_nq[g]),
            .i_rem   (c_rem[g]),
            .i_div   (c_div[g]),
            .o_valid (c_valid[g+1]),
            .o_side  (c_side[g+1]),
            .o_nq    (c_nq[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_div   (c_div[g+1])
        );
    end

    // -------- output register: sign, zero divisor, unused command --------
    t_side                   w_fs;
    logic [RESULT_WIDTH-1:0] w_q;
    logic [RESULT_WIDTH-1:0] w_res;
    logic [RESULT_WIDTH-1:0] r_result;
    logic                    r_dz;

    assign w_fs = c_side[NW];
    assign w_q  = RESULT_WIDTH'(c_nq[NW]);

    always_comb begin
        if (w_fs.cmd != CMD_MUL && w_fs.cmd != CMD_DIV && w_fs.cmd != CMD_MULDIV) begin
            w_res = '0;
        end else if (w_fs.dz) begin
            w_res = ZERO_DIV_VALUE;
        end else begin
            w_res = w_fs.neg ? (~w_q + 1'b1) : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= c_valid[NW];
        end
        if (w_en) begin
            r_result <= w_res;
            r_dz     <= w_fs.dz;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result         = r_result;
    assign o_out.divide_by_zero = r_dz;

    // -------- checks --------
    a_dz_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.divide_by_zero |-> o_out.result == ZERO_DIV_VALUE)
        else $error("zero divisor result mismatch");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready not tied to output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
endmodule

FILE: tb/fixed_point_mul_div_unit_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fixed_point_mul_div_unit_core_tb
// self-checking bench: directed table of corner cases, then random commands
// with random idle on both channels and one long output hold-off; every output
// transfer is checked against a typed-in value or the built-in 16.16 predictor
// ---------------------------------------------------------------------------
module fixed_point_mul_div_unit_core_tb;
    import fmdu_pkg::*;

    localparam int  FRAC         = 16;
    localparam int  LATENCY      = 2 * FIELD_WIDTH + 2;
    localparam int  NUM_RANDOM   = 600;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam bit  [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        bit                 known;      // expected value typed in the table
        logic signed [63:0] result;
        logic               dz;
    } t_row;

    typedef struct {
        logic signed [63:0] result;
        logic               dz;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    fmdu_in_if  in_ch ();
    fmdu_out_if out_ch ();

    fixed_point_mul_div_unit_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_answer     pending_answers[$];
    t_row        directed[$];
    int          error_count;
    int          checked_count;
    int          dz_count;
    int          cycle_count;
    bit          stim_done;
    bit          quiet_in;       // no-idle stretch on the input side
    bit          quiet_out;      // no-stall stretch on the output side
    bit          hold_off;       // long receiver hold-off
    int          cmd_seen[4];

    // magnitude of a 32-bit two's complement value, exact for the minimum
    function automatic logic [63:0] magnitude(input logic signed [31:0] v);
        logic [63:0] w;
        w = {{32{v[31]}}, v};
        return v[31] ? (~w + 64'd1) : w;
    endfunction

    function automatic t_answer mul_div_predict(input logic [1:0] command,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] c);
        t_answer     ans;
        logic [63:0] ma, mb, mc, q;
        logic        neg;
        ma = magnitude(a);
        mb = magnitude(b);
        mc = magnitude(c);
        ans.result = '0;
        ans.dz     = 1'b0;
        neg        = 1'b0;
        q          = '0;
        case (command)
            CMD_MUL: begin
                q   = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                neg = a[31] ^ b[31];
            end
            CMD_DIV: begin
                if (mb == 0) ans.dz = 1'b1;
                else q = ((ma << FRAC) + (mb >> 1)) / mb;
                neg = a[31] ^ b[31];
            end
            CMD_MULDIV: begin
                if (mc == 0) ans.dz = 1'b1;
                else q = (ma * mb + (mc >> 1)) / mc;
                neg = a[31] ^ b[31] ^ c[31];
            end
            default: ;
        endcase
        if (ans.dz) ans.result = ZERO_DIV_VALUE;
        else if (command != CMD_UNUSED) ans.result = neg ? -q : q;
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch @%0d: %s got %h expected %h", cycle_count, what, got, want);
    endtask

    function automatic t_row row(input logic [1:0] cmd, input logic [31:0] a,
                                 input logic [31:0] b, input logic [31:0] c,
                                 input bit known = 0, input logic [63:0] res = 0,
                                 input logic dz = 0);
        t_row r;
        r.command = cmd; r.a = a; r.b = b; r.c = c;
        r.known = known; r.result = res; r.dz = dz;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5:    return $urandom_range(0, 1) ? $urandom_range(0, 32'h3_FFFF)
                                                 : -$urandom_range(0, 32'h3_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // directed table
    initial begin
        // multiply extremes and rounding
        directed.push_back(row(CMD_MUL, 32'h0001_0000, 32'h0001_0000, 0, 1, 64'h1_0000, 0));
        directed.push_back(row(CMD_MUL, 0, 32'h8000_0000, 0, 1, 0, 0));
        directed.push_back(row(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0,
                               1, 64'h4000_0000_0000, 0));
        directed.push_back(row(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(row(CMD_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        directed.push_back(row(CMD_MUL, 32'h0000_8000, 32'h0000_0001, 0));
        directed.push_back(row(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 0));
        // divide, zero divisor of either sign of dividend
        directed.push_back(row(CMD_DIV, 32'h0001_0000, 0, 0, 1, ZERO_DIV_VALUE, 1));
        directed.push_back(row(CMD_DIV, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1, ZERO_DIV_VALUE, 1));
        directed.push_back(row(CMD_DIV, 32'h0001_0000, 32'h0001_0000, 0, 1, 64'h1_0000, 0));
        directed.push_back(row(CMD_DIV, 32'h8000_0000, 32'h0000_0001, 0));
        directed.push_back(row(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        directed.push_back(row(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0));
        directed.push_back(row(CMD_DIV, 0, 32'hFFFF_FFFF, 0));
        // multiply then divide
        directed.push_back(row(CMD_MULDIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                               1, ZERO_DIV_VALUE, 1));
        directed.push_back(row(CMD_MULDIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                               1, 64'h4000_0000_0000_0000, 0));
        directed.push_back(row(CMD_MULDIV, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
        directed.push_back(row(CMD_MULDIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(row(CMD_MULDIV, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(row(CMD_MULDIV, 32'h0000_0003, 32'h0000_0001, 32'h0000_0002));
        // unused command gives zero
        directed.push_back(row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0));
        directed.push_back(row(CMD_UNUSED, 32'h1234_5678, 0, 0, 1, 0, 0));
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** fixed_point_mul_div_unit_core: FAILED **");
            $finish;
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        hold_off = 1'b0;
        wait (stim_done == 1'b0 && directed.size() > 0);
        @(posedge i_clk iff in_ch.valid && in_ch.ready && cmd_seen[0] > 30);
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // output side: random stall, check on every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_answer want;
                if (pending_answers.size() == 0) begin
                    error_count++;
                    $display("unexpected output transfer @%0d", cycle_count);
                end else begin
                    want = pending_answers.pop_front();
                    if (out_ch.result !== want.result)
                        report_mismatch("result", out_ch.result, want.result);
                    if (out_ch.divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", 64'(out_ch.divide_by_zero),
                                        64'(want.dz));
                    checked_count++;
                    if (want.dz) dz_count++;
                end
            end
            out_ch.ready <= !hold_off && (quiet_out || $urandom_range(0, 99) >= 37);
        end
    end

    task automatic send(input t_row r);
        t_answer ans;
        if (r.known) begin
            ans.result = r.result;
            ans.dz     = r.dz;
        end else begin
            ans = mul_div_predict(r.command, r.a, r.b, r.c);
        end
        // random idle before offering the transfer
        while (!quiet_in && $urandom_range(0, 99) < 37) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= r.command;
        in_ch.operand_a <= r.a;
        in_ch.operand_b <= r.b;
        in_ch.operand_c <= r.c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_answers.push_back(ans);
        cmd_seen[r.command]++;
    endtask

    initial begin
        t_row r;
        int   waited;
        error_count = 0; checked_count = 0; dz_count = 0; cycle_count = 0;
        stim_done = 1'b0; quiet_in = 1'b0; quiet_out = 1'b0;
        in_ch.valid = 1'b0; in_ch.command = CMD_MUL;
        in_ch.operand_a = '0; in_ch.operand_b = '0; in_ch.operand_c = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send(directed[i]);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // stretch with no idling on either side
            quiet_in  = (n >= 200 && n < 300);
            quiet_out = quiet_in;
            r = row(($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2)),
                    rand_operand(), rand_operand(), rand_operand());
            send(r);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        waited = 0;
        while (pending_answers.size() != 0 && waited < 100 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(posedge i_clk);

        $display("ran %0d multiply, %0d divide, %0d multiply-divide, %0d unused commands",
                 cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("checked %0d results, %0d with zero divisor, %0d still pending",
                 checked_count, dz_count, pending_answers.size());
        if (pending_answers.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("** fixed_point_mul_div_unit_core: PASSED **");
        end else begin
            $display("** fixed_point_mul_div_unit_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: fixed_point_mul_div_unit_core.f
hdl/fmdu_pkg.sv
hdl/fmdu_if.sv
hdl/fmdu_div_cell.sv
hdl/fixed_point_mul_div_unit_core.sv
tb/fixed_point_mul_div_unit_core_tb.sv
